// ===== rtl/cpci_pkg.sv =====
// Shared types, constants and arithmetic helpers for the circular interpolator.
`default_nettype none

package cpci_pkg;

    // Width of the current point coordinates (two's complement, wraps on overflow).
    localparam int COORD_BITS = 16;

    // Fixed field widths.
    localparam int CENTER_BITS = 15;
    localparam int RADIUS_BITS = 13;
    localparam int RR_BITS     = 2 * RADIUS_BITS;

    // Working width for sign-extended coordinate arithmetic.
    localparam int WIDE_BITS = 34;

    // Exact offset of the point from the center.
    localparam int OFF_BITS = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS) + 1;

    // Offset magnitude after clamping to 2^30.
    localparam int MAG_BITS = (OFF_BITS > 31) ? 31 : OFF_BITS;
    localparam int SQ_BITS  = 2 * MAG_BITS;
    localparam int DEV_BITS = SQ_BITS + 2;

    localparam logic [63:0] SAT_LIMIT = 64'd1 << 30;

    // Function codes of an input item.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Codes of the step_axis result field.
    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Y    = 2'd2;

    // Controls for one axis lane.
    typedef struct packed {
        logic adv;    // an item is being processed this cycle
        logic load;   // start item: load the start point and center
        logic step;   // this axis moves by one unit
        logic neg;    // move in the negative direction
    } lane_ctl_t;

    // Move chosen by the steering logic.
    typedef struct packed {
        logic en;     // a move is made
        logic on_y;   // move along Y rather than X
        logic neg;    // move in the negative direction
    } move_t;

    // Sign-extends a center coordinate to the working width.
    function automatic logic signed [WIDE_BITS-1:0] sext_center(
        input logic signed [CENTER_BITS-1:0] v
    );
        return {{(WIDE_BITS - CENTER_BITS){v[CENTER_BITS-1]}}, v};
    endfunction

    // Sign-extends a point coordinate to the working width.
    function automatic logic signed [WIDE_BITS-1:0] sext_coord(
        input logic signed [COORD_BITS-1:0] v
    );
        return {{(WIDE_BITS - COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    // Magnitude of an offset, clamped to 2^30 before squaring.
    function automatic logic [MAG_BITS-1:0] sat_mag(
        input logic signed [OFF_BITS-1:0] off
    );
        logic [OFF_BITS-1:0] mag;
        logic [63:0]         wide;
        mag  = off[OFF_BITS-1] ? (~off + 1'b1) : off;
        wide = 64'(mag);
        if (wide > SAT_LIMIT) begin
            return MAG_BITS'(SAT_LIMIT);
        end
        return MAG_BITS'(wide);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cpci_lane.sv =====
// One axis lane: current point, offset from the center and its clamped square.
`default_nettype none

module cpci_lane (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire cpci_pkg::lane_ctl_t                   ctl,
    input  wire logic signed [cpci_pkg::COORD_BITS-1:0]  load_pt,
    input  wire logic signed [cpci_pkg::CENTER_BITS-1:0] load_c,
    output logic signed [cpci_pkg::COORD_BITS-1:0]       pt,
    output logic signed [cpci_pkg::COORD_BITS-1:0]       pt_next,
    output logic signed [cpci_pkg::OFF_BITS-1:0]         off,
    output logic [cpci_pkg::SQ_BITS-1:0]                 sq,
    output logic                                         at_start
);

    logic signed [cpci_pkg::COORD_BITS-1:0]  pt_reg;
    logic signed [cpci_pkg::COORD_BITS-1:0]  st_reg, st_next;
    logic signed [cpci_pkg::CENTER_BITS-1:0] c_reg, c_next;
    logic signed [cpci_pkg::OFF_BITS-1:0]    off_reg, off_next;
    logic [cpci_pkg::SQ_BITS-1:0]            sq_reg, sq_next;
    logic [cpci_pkg::MAG_BITS-1:0]           mag;
    logic signed [cpci_pkg::WIDE_BITS-1:0]   diff;

    always_comb
    begin
        if (ctl.load) begin
            pt_next = load_pt;
        end else if (ctl.step) begin
            pt_next = ctl.neg ? (pt_reg - cpci_pkg::COORD_BITS'(1))
                              : (pt_reg + cpci_pkg::COORD_BITS'(1));
        end else begin
            pt_next = pt_reg;
        end
        c_next   = ctl.load ? load_c : c_reg;
        st_next  = ctl.load ? load_pt : st_reg;
        diff     = cpci_pkg::sext_coord(pt_next) - cpci_pkg::sext_center(c_next);
        off_next = diff[cpci_pkg::OFF_BITS-1:0];
        mag      = cpci_pkg::sat_mag(off_next);
        sq_next  = mag * mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pt_reg  <= '0;
            st_reg  <= '0;
            c_reg   <= '0;
            off_reg <= '0;
            sq_reg  <= '0;
        end else if (ctl.adv) begin
            pt_reg  <= pt_next;
            st_reg  <= st_next;
            c_reg   <= c_next;
            off_reg <= off_next;
            sq_reg  <= sq_next;
        end
    end

    assign pt       = pt_reg;
    assign off      = off_reg;
    assign sq       = sq_reg;
    assign at_start = (pt_next == st_reg);

endmodule

`default_nettype wire

// ===== rtl/cpci_steer.sv =====
// Quadrant decode and deviation sign test that choose the next unit move.
`default_nettype none

module cpci_steer (
    input  wire logic signed [cpci_pkg::OFF_BITS-1:0] off_x,
    input  wire logic signed [cpci_pkg::OFF_BITS-1:0] off_y,
    input  wire logic [cpci_pkg::SQ_BITS-1:0]         sq_x,
    input  wire logic [cpci_pkg::SQ_BITS-1:0]         sq_y,
    input  wire logic [cpci_pkg::RR_BITS-1:0]         rr,
    input  wire logic                                 cw,
    input  wire logic                                 first,
    output cpci_pkg::move_t                           mv
);

    typedef enum logic [2:0] {
        Q_NONE,
        Q_ONE,
        Q_TWO,
        Q_THREE,
        Q_FOUR
    } quad_t;

    logic [cpci_pkg::DEV_BITS-1:0] dev;
    logic  f_neg, f_pos;
    logic  x_pos, x_neg, y_pos, y_neg;
    quad_t quad;

    always_comb
    begin
        // Deviation is forced to zero until the first move after a start.
        dev   = cpci_pkg::DEV_BITS'(sq_x) + cpci_pkg::DEV_BITS'(sq_y)
              - cpci_pkg::DEV_BITS'(rr);
        f_neg = !first && dev[cpci_pkg::DEV_BITS-1];
        f_pos = !first && !dev[cpci_pkg::DEV_BITS-1] && (dev != '0);

        x_neg = off_x[cpci_pkg::OFF_BITS-1];
        x_pos = !x_neg && (off_x != '0);
        y_neg = off_y[cpci_pkg::OFF_BITS-1];
        y_pos = !y_neg && (off_y != '0);

        if (x_pos && !y_neg) begin
            quad = Q_ONE;
        end else if (!x_pos && y_pos) begin
            quad = Q_TWO;
        end else if (x_neg && !y_pos) begin
            quad = Q_THREE;
        end else if (!x_neg && y_neg) begin
            quad = Q_FOUR;
        end else begin
            quad = Q_NONE;
        end

        mv = '0;
        case (quad)
            Q_ONE: begin
                mv.en = 1'b1;
                if (cw) begin
                    mv.on_y = !f_neg;
                    mv.neg  = !f_neg;
                end else begin
                    mv.on_y = !f_pos;
                    mv.neg  = f_pos;
                end
            end
            Q_TWO: begin
                mv.en = 1'b1;
                if (cw) begin
                    mv.on_y = f_neg;
                    mv.neg  = 1'b0;
                end else begin
                    mv.on_y = f_pos;
                    mv.neg  = 1'b1;
                end
            end
            Q_THREE: begin
                mv.en = 1'b1;
                if (cw) begin
                    mv.on_y = !f_neg;
                    mv.neg  = f_neg;
                end else begin
                    mv.on_y = !f_pos;
                    mv.neg  = !f_pos;
                end
            end
            Q_FOUR: begin
                mv.en = 1'b1;
                if (cw) begin
                    mv.on_y = f_neg;
                    mv.neg  = 1'b1;
                end else begin
                    mv.on_y = f_pos;
                    mv.neg  = 1'b0;
                end
            end
            default: begin
                mv = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/circular_point_comparison_interpolator.sv =====
// Top level of the point-by-point comparison full-circle interpolator.
// A result passes through the input register, then the result register. Throughput:
// one item per cycle unless the result channel stalls, set by the single update of
// the point lanes and the deviation sign that every tick reads from the previous one.
// Reset (rst_n, asynchronous, active low) empties both registers, puts the point
// at the origin, clears center, radius and direction, and leaves the block idle.
`default_nettype none

module circular_point_comparison_interpolator (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // Input channel
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic                                     func,
    input  wire logic signed [cpci_pkg::CENTER_BITS-1:0]  center_x,
    input  wire logic signed [cpci_pkg::CENTER_BITS-1:0]  center_y,
    input  wire logic [cpci_pkg::RADIUS_BITS-1:0]         radius,
    input  wire logic                                     clockwise,
    // Result channel
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic [1:0]                                    step_axis,
    output logic                                          step_negative,
    output logic signed [cpci_pkg::COORD_BITS-1:0]        pos_x,
    output logic signed [cpci_pkg::COORD_BITS-1:0]        pos_y,
    output logic                                          done_res,
    output logic                                          busy_res
);

    // ------------------------------------------------------------------
    // Input register. It is refilled in the same cycle that its item moves
    // on, so a waiting result never stops the next transfer from being taken
    // while the result register can still drain.
    // ------------------------------------------------------------------
    logic                                    in_valid_reg;
    logic                                    in_func_reg;
    logic signed [cpci_pkg::CENTER_BITS-1:0] in_cx_reg;
    logic signed [cpci_pkg::CENTER_BITS-1:0] in_cy_reg;
    logic [cpci_pkg::RADIUS_BITS-1:0]        in_r_reg;
    logic                                    in_cw_reg;

    // Arc control state.
    logic                                    active_reg, active_next;
    logic                                    first_reg, first_next;
    logic                                    cw_reg, cw_next;
    logic [cpci_pkg::RR_BITS-1:0]            rr_reg, rr_next;

    // Result register.
    logic                                    out_valid_reg;
    logic [1:0]                              out_axis_reg, out_axis_next;
    logic                                    out_neg_reg, out_neg_next;
    logic signed [cpci_pkg::COORD_BITS-1:0]  out_x_reg;
    logic signed [cpci_pkg::COORD_BITS-1:0]  out_y_reg;
    logic                                    out_done_reg, out_done_next;
    logic                                    out_busy_reg;

    logic advance;   // result register can take a new value
    logic proc;      // the item in the input register is processed now
    logic is_start;
    logic mv_en;

    cpci_pkg::lane_ctl_t ctl_x, ctl_y;
    cpci_pkg::move_t     mv;

    logic signed [cpci_pkg::COORD_BITS-1:0] load_x, load_y;
    logic signed [cpci_pkg::COORD_BITS-1:0] pt_x, pt_y, pt_x_next, pt_y_next;
    logic signed [cpci_pkg::OFF_BITS-1:0]   off_x, off_y;
    logic [cpci_pkg::SQ_BITS-1:0]           sq_x, sq_y;
    logic                                   x_at_start, y_at_start;
    logic signed [cpci_pkg::WIDE_BITS-1:0]  top_y;

    assign advance  = !out_valid_reg || out_ready;
    assign proc     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_func_reg <= func;
            in_cx_reg   <= center_x;
            in_cy_reg   <= center_y;
            in_r_reg    <= radius;
            in_cw_reg   <= clockwise;
        end
    end

    // ------------------------------------------------------------------
    // Start point: the top of the circle, both coordinates wrapped into the
    // point width.
    // ------------------------------------------------------------------
    assign top_y  = cpci_pkg::sext_center(in_cy_reg) + cpci_pkg::WIDE_BITS'(in_r_reg);
    assign load_x = cpci_pkg::COORD_BITS'(cpci_pkg::sext_center(in_cx_reg));
    assign load_y = top_y[cpci_pkg::COORD_BITS-1:0];

    assign is_start = (in_func_reg == cpci_pkg::FUNC_START);

    // The steering logic looks at the state left by the previous item.
    cpci_steer u_steer (
        .off_x (off_x),
        .off_y (off_y),
        .sq_x  (sq_x),
        .sq_y  (sq_y),
        .rr    (rr_reg),
        .cw    (cw_reg),
        .first (first_reg),
        .mv    (mv)
    );

    // A tick moves only while an arc is in progress.
    assign mv_en = !is_start && active_reg && mv.en;

    always_comb
    begin
        ctl_x.adv  = proc;
        ctl_x.load = is_start;
        ctl_x.step = mv_en && !mv.on_y;
        ctl_x.neg  = mv.neg;

        ctl_y.adv  = proc;
        ctl_y.load = is_start;
        ctl_y.step = mv_en && mv.on_y;
        ctl_y.neg  = mv.neg;
    end

    cpci_lane u_lane_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_x),
        .load_pt  (load_x),
        .load_c   (in_cx_reg),
        .pt       (pt_x),
        .pt_next  (pt_x_next),
        .off      (off_x),
        .sq       (sq_x),
        .at_start (x_at_start)
    );

    cpci_lane u_lane_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_y),
        .load_pt  (load_y),
        .load_c   (in_cy_reg),
        .pt       (pt_y),
        .pt_next  (pt_y_next),
        .off      (off_y),
        .sq       (sq_y),
        .at_start (y_at_start)
    );

    // ------------------------------------------------------------------
    // Arc control and result values.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_done_next = mv_en && x_at_start && y_at_start;
        if (is_start) begin
            // A zero radius loads the center and leaves the block idle.
            active_next = (in_r_reg != '0);
            first_next  = 1'b1;
            cw_next     = in_cw_reg;
            rr_next     = in_r_reg * in_r_reg;
        end else begin
            active_next = active_reg && !out_done_next;
            first_next  = first_reg && !mv_en;
            cw_next     = cw_reg;
            rr_next     = rr_reg;
        end

        if (!mv_en) begin
            out_axis_next = cpci_pkg::AXIS_NONE;
        end else if (mv.on_y) begin
            out_axis_next = cpci_pkg::AXIS_Y;
        end else begin
            out_axis_next = cpci_pkg::AXIS_X;
        end
        out_neg_next = mv_en && mv.neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg    <= 1'b0;
            first_reg     <= 1'b1;
            cw_reg        <= 1'b0;
            rr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (proc) begin
                active_reg <= active_next;
                first_reg  <= first_next;
                cw_reg     <= cw_next;
                rr_reg     <= rr_next;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc) begin
            out_axis_reg <= out_axis_next;
            out_neg_reg  <= out_neg_next;
            out_x_reg    <= pt_x_next;
            out_y_reg    <= pt_y_next;
            out_done_reg <= out_done_next;
            out_busy_reg <= active_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign step_axis     = out_axis_reg;
    assign step_negative = out_neg_reg;
    assign pos_x         = out_x_reg;
    assign pos_y         = out_y_reg;
    assign done_res      = out_done_reg;
    assign busy_res      = out_busy_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A step along X leaves Y alone and changes X.
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && ctl_x.step) |=> (pt_y == $past(pt_y)) && (pt_x != $past(pt_x)))
    else $error("X step did not move X alone");

    // A step along Y leaves X alone and changes Y.
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && ctl_y.step) |=> (pt_x == $past(pt_x)) && (pt_y != $past(pt_y)))
    else $error("Y step did not move Y alone");

    // A start with a nonzero radius opens an arc with the deviation forced to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && is_start && (in_r_reg != '0)) |=> (active_reg && first_reg))
    else $error("start did not open an arc");

    // Closing the circle always ends the arc.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg)
            |-> (!out_busy_reg && (out_axis_reg != cpci_pkg::AXIS_NONE)))
    else $error("done reported with the arc still open or without a move");

    // No move carries no direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_axis_reg == cpci_pkg::AXIS_NONE)) |-> !out_neg_reg)
    else $error("negative flag set without a move");

endmodule

`default_nettype wire

// ===== tb/circular_point_comparison_interpolator_tb.sv =====
// Self-checking testbench for the point-by-point comparison circular interpolator.
`timescale 1ns / 100ps

module circular_point_comparison_interpolator_tb;

    // One input transfer as the driver presents it on the ports.
    typedef struct packed {
        logic                                    func;
        logic signed [cpci_pkg::CENTER_BITS-1:0] center_x;
        logic signed [cpci_pkg::CENTER_BITS-1:0] center_y;
        logic [cpci_pkg::RADIUS_BITS-1:0]        radius;
        logic                                    clockwise;
    } arc_cmd_t;

    // One result transfer, field for field as the block reports it.
    typedef struct packed {
        logic [1:0]                             step_axis;
        logic                                   step_negative;
        logic signed [cpci_pkg::COORD_BITS-1:0] pos_x;
        logic signed [cpci_pkg::COORD_BITS-1:0] pos_y;
        logic                                   done_res;
        logic                                   busy_res;
    } step_report_t;

    // Position of the point relative to the center; NONE means it sits on the center.
    typedef enum int {QUAD_NONE, QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_t;

    // Clock, reset and port signals. Every input starts at a known value.
    logic                                    clk = 1'b0;
    logic                                    rst_n = 1'b0;
    logic                                    in_valid = 1'b0;
    logic                                    in_ready;
    logic                                    func = cpci_pkg::FUNC_TICK;
    logic signed [cpci_pkg::CENTER_BITS-1:0] center_x = '0;
    logic signed [cpci_pkg::CENTER_BITS-1:0] center_y = '0;
    logic [cpci_pkg::RADIUS_BITS-1:0]        radius = '0;
    logic                                    clockwise = 1'b0;
    logic                                    out_valid;
    logic                                    out_ready = 1'b0;
    logic [1:0]                              step_axis;
    logic                                    step_negative;
    logic signed [cpci_pkg::COORD_BITS-1:0]  pos_x;
    logic signed [cpci_pkg::COORD_BITS-1:0]  pos_y;
    logic                                    done_res;
    logic                                    busy_res;

    // Commands waiting to be driven, and the reports the block still owes us.
    arc_cmd_t     pending_cmds[$];
    step_report_t owed_reports[$];
    arc_cmd_t     cmd_on_bus;

    // Idle and stall rates in percent, changed by the stimulus phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // Shadow copy of the interpolator state, advanced once per accepted command.
    logic signed [cpci_pkg::COORD_BITS-1:0]  trk_x;
    logic signed [cpci_pkg::COORD_BITS-1:0]  trk_y;
    logic signed [cpci_pkg::CENTER_BITS-1:0] trk_cx;
    logic signed [cpci_pkg::CENTER_BITS-1:0] trk_cy;
    logic [cpci_pkg::RADIUS_BITS-1:0]        trk_r;
    logic                                    trk_cw;
    longint                                  trk_dev;
    logic                                    trk_active;

    circular_point_comparison_interpolator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius       (radius),
        .clockwise    (clockwise),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .step_axis    (step_axis),
        .step_negative(step_negative),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .done_res     (done_res),
        .busy_res     (busy_res)
    );

    always #5 clk = ~clk;

    // Clamps an offset from the center to +-2^30 before it is squared.
    function automatic longint clamp_offset(input longint v);
        longint lim;
        lim = longint'(1) << 30;
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Advances the shadow state by one command and returns the report it should cause.
    // A start places the point at the top of the circle; a tick picks one unit move
    // from the quadrant, the direction and the sign of the stored deviation, then
    // recomputes the deviation x^2 + y^2 - R^2 at the new point.
    function automatic step_report_t interpolate_step(input arc_cmd_t cmd);
        step_report_t rep;
        longint       dx;
        longint       dy;
        longint       f;
        quadrant_t    quad;
        logic [1:0]   axis;
        logic         neg;
        axis = cpci_pkg::AXIS_NONE;
        neg  = 1'b0;
        rep  = '0;
        if (cmd.func == cpci_pkg::FUNC_START) begin
            trk_cx     = cmd.center_x;
            trk_cy     = cmd.center_y;
            trk_r      = cmd.radius;
            trk_cw     = cmd.clockwise;
            trk_x      = cpci_pkg::COORD_BITS'(longint'(cmd.center_x));
            trk_y      = cpci_pkg::COORD_BITS'(longint'(cmd.center_y)
                                               + longint'(cmd.radius));
            trk_dev    = 0;
            trk_active = (cmd.radius != '0);
        end else if (trk_active) begin
            dx = longint'(trk_x) - longint'(trk_cx);
            dy = longint'(trk_y) - longint'(trk_cy);
            f  = trk_dev;
            if (dx > 0 && dy >= 0) begin
                quad = QUAD_I;
            end else if (dx <= 0 && dy > 0) begin
                quad = QUAD_II;
            end else if (dx < 0 && dy <= 0) begin
                quad = QUAD_III;
            end else if (dx >= 0 && dy < 0) begin
                quad = QUAD_IV;
            end else begin
                quad = QUAD_NONE;
            end

            // Clockwise moves lean on f >= 0; counterclockwise ones on f > 0, except
            // in the first quadrant where a zero deviation still climbs in Y.
            case (quad)
                QUAD_I: begin
                    if (trk_cw) begin
                        if (f >= 0) begin axis = cpci_pkg::AXIS_Y; neg = 1'b1; end
                        else        begin axis = cpci_pkg::AXIS_X; neg = 1'b0; end
                    end else begin
                        if (f <= 0) begin axis = cpci_pkg::AXIS_Y; neg = 1'b0; end
                        else        begin axis = cpci_pkg::AXIS_X; neg = 1'b1; end
                    end
                end
                QUAD_II: begin
                    if (trk_cw) begin
                        if (f >= 0) begin axis = cpci_pkg::AXIS_X; neg = 1'b0; end
                        else        begin axis = cpci_pkg::AXIS_Y; neg = 1'b0; end
                    end else begin
                        if (f > 0)  begin axis = cpci_pkg::AXIS_Y; neg = 1'b1; end
                        else        begin axis = cpci_pkg::AXIS_X; neg = 1'b1; end
                    end
                end
                QUAD_III: begin
                    if (trk_cw) begin
                        if (f >= 0) begin axis = cpci_pkg::AXIS_Y; neg = 1'b0; end
                        else        begin axis = cpci_pkg::AXIS_X; neg = 1'b1; end
                    end else begin
                        if (f > 0)  begin axis = cpci_pkg::AXIS_X; neg = 1'b0; end
                        else        begin axis = cpci_pkg::AXIS_Y; neg = 1'b1; end
                    end
                end
                QUAD_IV: begin
                    if (trk_cw) begin
                        if (f >= 0) begin axis = cpci_pkg::AXIS_X; neg = 1'b1; end
                        else        begin axis = cpci_pkg::AXIS_Y; neg = 1'b1; end
                    end else begin
                        if (f > 0)  begin axis = cpci_pkg::AXIS_Y; neg = 1'b0; end
                        else        begin axis = cpci_pkg::AXIS_X; neg = 1'b0; end
                    end
                end
                default: begin
                    axis = cpci_pkg::AXIS_NONE;
                end
            endcase

            if (axis != cpci_pkg::AXIS_NONE) begin
                if (axis == cpci_pkg::AXIS_X) begin
                    trk_x = trk_x + (neg ? -16'sd1 : 16'sd1);
                end else begin
                    trk_y = trk_y + (neg ? -16'sd1 : 16'sd1);
                end
                dx = clamp_offset(longint'(trk_x) - longint'(trk_cx));
                dy = clamp_offset(longint'(trk_y) - longint'(trk_cy));
                f  = dx * dx + dy * dy - longint'(trk_r) * longint'(trk_r);
                if (f > 64'sd2147483647) begin
                    f = 64'sd2147483647;
                end
                if (f < -64'sd2147483648) begin
                    f = -64'sd2147483648;
                end
                trk_dev = f;
                // Back at the starting point closes the circle and ends the arc.
                if (trk_x == cpci_pkg::COORD_BITS'(longint'(trk_cx)) &&
                    trk_y == cpci_pkg::COORD_BITS'(longint'(trk_cy) + longint'(trk_r)))
                begin
                    rep.done_res = 1'b1;
                    trk_active   = 1'b0;
                end
            end
        end
        rep.step_axis     = axis;
        rep.step_negative = neg;
        rep.pos_x         = trk_x;
        rep.pos_y         = trk_y;
        rep.busy_res      = trk_active;
        return rep;
    endfunction

    // Driver. A transfer takes place when valid and ready are both high at the edge;
    // the accepted command goes through the predictor right then, so the owed
    // reports stay in transfer order. A new command is only put up once the bus is
    // free, which keeps valid and the payload stable while the block stalls.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                owed_reports.push_back(interpolate_step(cmd_on_bus));
            end
            if (!in_valid || in_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cmd_on_bus = pending_cmds.pop_front();
                    in_valid  <= 1'b1;
                    func      <= cmd_on_bus.func;
                    center_x  <= cmd_on_bus.center_x;
                    center_y  <= cmd_on_bus.center_y;
                    radius    <= cmd_on_bus.radius;
                    clockwise <= cmd_on_bus.clockwise;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each result transfer is matched against the oldest owed report.
    // Ready is redrawn every cycle, so stalls land on every phase of the block.
    always @(posedge clk) begin
        step_report_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (owed_reports.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10) begin
                        $display("ERROR: result with nothing expected: %s",
                                 $sformatf("axis=%0d neg=%0d pos=(%0d,%0d) done=%0d busy=%0d",
                                           step_axis, step_negative, pos_x, pos_y,
                                           done_res, busy_res));
                    end
                end else begin
                    want = owed_reports.pop_front();
                    if (step_axis !== want.step_axis ||
                        step_negative !== want.step_negative ||
                        pos_x !== want.pos_x || pos_y !== want.pos_y ||
                        done_res !== want.done_res || busy_res !== want.busy_res) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10) begin
                            $display("ERROR: expected axis=%0d neg=%0d pos=(%0d,%0d) %s",
                                     want.step_axis, want.step_negative, want.pos_x,
                                     want.pos_y, $sformatf("done=%0d busy=%0d",
                                                           want.done_res, want.busy_res));
                            $display("       actual   axis=%0d neg=%0d pos=(%0d,%0d) %s",
                                     step_axis, step_negative, pos_x, pos_y,
                                     $sformatf("done=%0d busy=%0d", done_res, busy_res));
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic queue_start(input logic signed [cpci_pkg::CENTER_BITS-1:0] cx,
                               input logic signed [cpci_pkg::CENTER_BITS-1:0] cy,
                               input logic [cpci_pkg::RADIUS_BITS-1:0] r,
                               input logic cw);
        arc_cmd_t cmd;
        cmd.func      = cpci_pkg::FUNC_START;
        cmd.center_x  = cx;
        cmd.center_y  = cy;
        cmd.radius    = r;
        cmd.clockwise = cw;
        pending_cmds.push_back(cmd);
    endtask

    // Ticks carry random junk in the start-only fields; the block must ignore it.
    task automatic queue_ticks(input int n);
        arc_cmd_t cmd;
        for (int i = 0; i < n; i++) begin
            cmd.func      = cpci_pkg::FUNC_TICK;
            cmd.center_x  = cpci_pkg::CENTER_BITS'($urandom);
            cmd.center_y  = cpci_pkg::CENTER_BITS'($urandom);
            cmd.radius    = cpci_pkg::RADIUS_BITS'($urandom);
            cmd.clockwise = 1'($urandom);
            pending_cmds.push_back(cmd);
        end
    endtask

    // Queues one stimulus phase. Most of it is well-formed arcs: a start with a
    // random center and mostly small radius, followed by enough ticks to close the
    // circle (8R moves) plus a few idle ticks. Some arcs are cut short by the next
    // start, large radii only get a handful of ticks, and a few loose commands and
    // zero-radius starts are mixed in as noise.
    task automatic queue_random_phase(input int n_items);
        int          counted;
        int          r;
        int          full;
        int          ticks;
        int          sel;
        logic [63:0] raw;
        arc_cmd_t    cmd;
        counted = 0;
        while (counted < n_items) begin
            if ($urandom_range(0, 99) < 8) begin
                raw = {$urandom, $urandom};
                cmd = raw[$bits(arc_cmd_t)-1:0];
                if (cmd.func == cpci_pkg::FUNC_START && cmd.radius == '0) begin
                    cmd.radius = cpci_pkg::RADIUS_BITS'($urandom_range(1, 6));
                end
                pending_cmds.push_back(cmd);
                counted = counted + 1;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 3) begin
                    r = 0;
                end else if (sel < 83) begin
                    r = $urandom_range(1, 8);
                end else if (sel < 94) begin
                    r = $urandom_range(9, 24);
                end else begin
                    r = $urandom_range(25, 8191);
                end
                queue_start(cpci_pkg::CENTER_BITS'($urandom),
                            cpci_pkg::CENTER_BITS'($urandom),
                            cpci_pkg::RADIUS_BITS'(r), 1'($urandom));
                full = 8 * r;
                if (r == 0) begin
                    ticks = $urandom_range(0, 2);
                end else if (r > 24) begin
                    ticks = $urandom_range(1, 40);
                end else if ($urandom_range(0, 99) < 75) begin
                    ticks = full + $urandom_range(0, 3);
                end else begin
                    ticks = $urandom_range(0, full);
                end
                queue_ticks(ticks);
                counted = counted + 1 + ((ticks < full) ? ticks : full);
            end
        end
    endtask

    // Blocks until the driver has handed every queued command to the block.
    task automatic drain_commands();
        while (pending_cmds.size() != 0 || in_valid) begin
            @(posedge clk);
        end
    endtask

    initial begin
        // Reset state of the shadow model matches the block after reset.
        trk_x      = '0;
        trk_y      = '0;
        trk_cx     = '0;
        trk_cy     = '0;
        trk_r      = '0;
        trk_cw     = 1'b0;
        trk_dev    = 0;
        trk_active = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, no idling. A tick straight after reset reports the origin.
        queue_ticks(1);
        // A zero radius puts the point on the center and leaves the block idle.
        queue_start(15'sh3FFF, -15'sd16384, 13'd0, 1'b1);
        queue_ticks(1);
        // Extreme centers with the largest radius, in both directions.
        queue_start(-15'sd16384, 15'sh3FFF, 13'h1FFF, 1'b1);
        queue_ticks(3);
        queue_start(15'sh3FFF, -15'sd16384, 13'h1FFF, 1'b0);
        queue_ticks(2);
        // A unit circle closed counterclockwise, then a tick after done.
        queue_start(15'sd0, 15'sd0, 13'd1, 1'b0);
        queue_ticks(9);
        // A clockwise unit circle abandoned halfway by the random part's first start.
        queue_start(-15'sd1, 15'sd1, 13'd1, 1'b1);
        queue_ticks(4);
        drain_commands();

        // Random phases: free running, sender idling, receiver stalling, then both.
        queue_random_phase(375);
        drain_commands();

        send_idle_pct = 56;
        queue_random_phase(375);
        drain_commands();

        send_idle_pct  = 0;
        recv_stall_pct = 56;
        queue_random_phase(375);
        drain_commands();

        send_idle_pct  = 20;
        recv_stall_pct = 20;
        queue_random_phase(375);
        drain_commands();

        // Let the owed reports come back, then keep the clock running so that any
        // stray extra result is caught.
        while (owed_reports.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && owed_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: a correct run finishes in well under a tenth of this.
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== circular_point_comparison_interpolator.f =====
rtl/cpci_pkg.sv
rtl/cpci_lane.sv
rtl/cpci_steer.sv
rtl/circular_point_comparison_interpolator.sv
tb/circular_point_comparison_interpolator_tb.sv
